@@ rtl/ttsr_pkg.sv @@
// shared constants and types for the scaled-replacement transposition table
`default_nettype none
package ttsr_pkg;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int SCALE_FLOOR_DEF = 256;
   localparam int SWEEP_STRIDE    = 8;
   localparam int KEY_W   = 64;
   localparam int EVAL_W  = 16;
   localparam int DEPTH_W = 10;
   localparam int BOUND_W = 2;
   localparam int STAT_W  = 32;

   typedef enum logic [1:0] {
      MODE_PROBE = 2'd0,
      MODE_STORE = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   localparam logic CSR_PROBE_SCALE    = 1'b0;
   localparam logic CSR_CAPACITY_LIMIT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [EVAL_W-1:0]  eval_v;
      logic [DEPTH_W-1:0] depth_v;
      logic [BOUND_W-1:0] bound_v;
   } entry_type;
endpackage
`default_nettype wire

@@ rtl/transposition_table_scaled_replace.sv @@
// top level of the scaled-replacement transposition table
`default_nettype none
// One item is taken while busy is low. A probe walks the slots in order
// through one synchronous memory read port, one slot a cycle, stopping at
// the first match, so how long it stays busy is set by where the key sits.
// A store may first run the eviction sweep over the valid bits, then a
// key walk, S_WAIT to decide and, if it writes, S_WRITE. A clear or an
// unused mode goes straight to S_WAIT. The result stands on the rsp_
// ports for one cycle with rsp_valid high, in the same cycle that busy
// falls; the receiver cannot stall.
// Valid bits live in flip-flops cleared by reset and by clear, so no
// clearing pass is needed; the slot contents sit in one memory.
module transposition_table_scaled_replace #(
   parameter int TABLE_DEPTH = ttsr_pkg::TABLE_DEPTH_DEF,
   parameter int SCALE_FLOOR = ttsr_pkg::SCALE_FLOOR_DEF
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            start,
   output logic                                  busy,
   input  wire  logic [1:0]                      req_mode,
   input  wire  logic [ttsr_pkg::KEY_W-1:0]      req_position_key,
   input  wire  logic signed [ttsr_pkg::EVAL_W-1:0]  req_eval_in,
   input  wire  logic signed [ttsr_pkg::DEPTH_W-1:0] req_depth_in,
   input  wire  logic [ttsr_pkg::BOUND_W-1:0]    req_bound_in,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic signed [ttsr_pkg::EVAL_W-1:0]    rsp_eval_out,
   output logic signed [ttsr_pkg::DEPTH_W-1:0]   rsp_depth_out,
   output logic [ttsr_pkg::BOUND_W-1:0]          rsp_bound_out,
   output logic                                  rsp_written,
   output logic [8:0]                            rsp_entry_count,
   output logic [ttsr_pkg::STAT_W-1:0]           rsp_lookup_total,
   output logic [ttsr_pkg::STAT_W-1:0]           rsp_hit_total,
   output logic [ttsr_pkg::STAT_W-1:0]           rsp_store_total,
   output logic [ttsr_pkg::STAT_W-1:0]           rsp_overwrite_total,
   input  wire  logic                            csr_valid,
   output logic                                  csr_ready,
   input  wire  logic                            csr_index,
   input  wire  logic [8:0]                      csr_data
);
   import ttsr_pkg::*;

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);
   localparam logic [STAT_W-1:0] SAT = '1;
   localparam logic signed [DEPTH_W:0] FLOOR_C = (DEPTH_W+1)'(SCALE_FLOOR);

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_FIND, S_WAIT, S_WRITE
   } state_type;

   // slot contents: one write port, one read port, registered read
   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic                 we;
   logic [AW-1:0]        wa, ra;
   entry_type            wd;
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // valid bits in flip-flops
   logic [TABLE_DEPTH-1:0] valid_ff;

   state_type state_ff;
   logic [1:0]          mode_ff;
   entry_type           req_ff;
   logic [AW-1:0]       idx_ff;     // address being issued
   logic [AW-1:0]       chk_ff;     // address of the data in rd_ff
   logic                chk_v_ff;   // rd_ff holds a slot to check
   logic                last_ff;    // the checked slot was the last
   logic [CW-1:0]       cnt_ff;
   logic [CW-1:0]       target_ff;
   logic [2:0]          ord_ff;     // occupied order modulo stride
   logic [AW-1:0]       free_ff;
   logic                free_v_ff;
   logic                found_ff;
   logic [AW-1:0]       found_a_ff;
   entry_type           found_e_ff;
   logic                probe_scale_ff;
   logic [8:0]          cap_ff;
   logic [STAT_W-1:0]   st_lk_ff, st_hit_ff, st_st_ff, st_ov_ff;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   function automatic logic scale_of(input logic [DEPTH_W-1:0] d);
      return $signed({d[DEPTH_W-1], d}) >= FLOOR_C;
   endfunction

   function automatic logic [STAT_W-1:0] bump(input logic [STAT_W-1:0] c);
      return (c == SAT) ? c : c + 1'b1;
   endfunction

   // effective capacity
   logic [CW-1:0] lim;
   always_comb begin
      if (cap_ff == 9'd0 || int'(cap_ff) > TABLE_DEPTH)
         lim = DEPTH_C;
      else
         lim = CW'(cap_ff);
   end

   // match on the slot just read
   logic match;
   assign match = chk_v_ff && valid_ff[chk_ff] && (rd_ff.key == req_ff.key);

   always_comb begin
      we = 1'b0;
      wa = found_ff ? found_a_ff : free_ff;
      wd = req_ff;
      ra = idx_ff;
      if (state_ff == S_WRITE) we = 1'b1;
   end

   // replacement decision once the walk has finished
   logic do_wr, over;
   always_comb begin
      do_wr = 1'b0;
      over  = 1'b0;
      if (found_ff) begin
         if (scale_of(found_e_ff.depth_v) != scale_of(req_ff.depth_v)) begin
            do_wr = !scale_of(found_e_ff.depth_v);
            over  = do_wr;
         end else if ($signed(found_e_ff.depth_v) > $signed(req_ff.depth_v)) begin
            do_wr = 1'b0;
         end else begin
            do_wr = 1'b1;
            over  = 1'b1;
         end
      end else begin
         do_wr = free_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid      <= 1'b0;
         valid_ff       <= '0;
         cnt_ff         <= '0;
         st_lk_ff       <= '0;
         st_hit_ff      <= '0;
         st_st_ff       <= '0;
         st_ov_ff       <= '0;
         probe_scale_ff <= 1'b0;
         cap_ff         <= '0;
         chk_v_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PROBE_SCALE:    probe_scale_ff <= csr_data[0];
               CSR_CAPACITY_LIMIT: cap_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               rsp_valid <= 1'b0;
               chk_v_ff  <= 1'b0;
               found_ff  <= 1'b0;
               free_v_ff <= 1'b0;
               idx_ff    <= '0;
               ord_ff    <= '0;
               if (start) begin
                  mode_ff <= req_mode;
                  req_ff  <= '{req_position_key, req_eval_in, req_depth_in, req_bound_in};
                  unique case (req_mode)
                     MODE_PROBE: begin
                        st_lk_ff <= bump(st_lk_ff);
                        state_ff <= S_FIND;
                     end
                     MODE_STORE: begin
                        if (cnt_ff >= lim) begin
                           target_ff <= CW'(cnt_ff / SWEEP_STRIDE) + 1'b1;
                           state_ff  <= S_SWEEP;
                        end else begin
                           state_ff <= S_FIND;
                        end
                     end
                     MODE_CLEAR: begin
                        valid_ff  <= '0;
                        cnt_ff    <= '0;
                        st_lk_ff  <= '0;
                        st_hit_ff <= '0;
                        st_st_ff  <= '0;
                        st_ov_ff  <= '0;
                        state_ff  <= S_WAIT;
                     end
                     default: state_ff <= S_WAIT;
                  endcase
               end
            end
            S_SWEEP: begin
               // walk the valid bits, dropping every eighth occupied slot
               rsp_valid <= 1'b0;
               if (valid_ff[idx_ff]) begin
                  if (ord_ff == 3'd0) begin
                     valid_ff[idx_ff] <= 1'b0;
                     cnt_ff    <= cnt_ff - 1'b1;
                     target_ff <= target_ff - 1'b1;
                  end
                  ord_ff <= ord_ff + 1'b1;
               end
               if ((valid_ff[idx_ff] && ord_ff == 3'd0 && target_ff == CW'(1))
                   || idx_ff == LAST_A || target_ff == '0) begin
                  idx_ff   <= '0;
                  state_ff <= S_FIND;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FIND: begin
               // issue address idx_ff, check the slot read last cycle
               rsp_valid <= 1'b0;
               chk_ff    <= idx_ff;
               last_ff   <= (idx_ff == LAST_A);
               if (!free_v_ff && !valid_ff[idx_ff]) begin
                  free_v_ff <= 1'b1;
                  free_ff   <= idx_ff;
               end
               if (match) begin
                  found_ff   <= 1'b1;
                  found_a_ff <= chk_ff;
                  found_e_ff <= rd_ff;
                  chk_v_ff   <= 1'b0;
                  state_ff   <= S_WAIT;
               end else if (chk_v_ff && last_ff) begin
                  chk_v_ff <= 1'b0;
                  state_ff <= S_WAIT;
               end else begin
                  chk_v_ff <= 1'b1;
                  // hold on the last address; last_ff ends the walk next cycle
                  if (idx_ff != LAST_A) idx_ff <= idx_ff + 1'b1;
               end
            end
            S_WAIT: begin
               // deliver the result or go on to the write
               rsp_written <= 1'b0;
               if (mode_ff == MODE_PROBE && found_ff
                   && scale_of(found_e_ff.depth_v) == probe_scale_ff) begin
                  rsp_hit       <= 1'b1;
                  rsp_eval_out  <= found_e_ff.eval_v;
                  rsp_depth_out <= found_e_ff.depth_v;
                  rsp_bound_out <= found_e_ff.bound_v;
                  st_hit_ff     <= bump(st_hit_ff);
                  rsp_hit_total <= bump(st_hit_ff);
               end else begin
                  rsp_hit       <= 1'b0;
                  rsp_eval_out  <= '0;
                  rsp_depth_out <= '0;
                  rsp_bound_out <= '0;
                  rsp_hit_total <= st_hit_ff;
               end
               rsp_entry_count     <= 9'(cnt_ff);
               rsp_lookup_total    <= st_lk_ff;
               rsp_store_total     <= st_st_ff;
               rsp_overwrite_total <= st_ov_ff;
               if (mode_ff == MODE_STORE && do_wr) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_WRITE;
               end else begin
                  rsp_valid <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_WRITE: begin
               valid_ff[wa] <= 1'b1;
               rsp_valid    <= 1'b1;
               rsp_written  <= 1'b1;
               st_st_ff     <= bump(st_st_ff);
               rsp_store_total <= bump(st_st_ff);
               if (over) begin
                  st_ov_ff            <= bump(st_ov_ff);
                  rsp_overwrite_total <= bump(st_ov_ff);
               end else begin
                  rsp_overwrite_total <= st_ov_ff;
               end
               if (!found_ff) begin
                  cnt_ff          <= cnt_ff + 1'b1;
                  rsp_entry_count <= 9'(cnt_ff + 1'b1);
               end else begin
                  rsp_entry_count <= 9'(cnt_ff);
               end
               rsp_lookup_total <= st_lk_ff;
               rsp_hit_total    <= st_hit_ff;
               state_ff         <= S_IDLE;
            end
            default: begin
               rsp_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire
